### rtl/ssid_pkg.sv
// Sorted set insert/delete: shared types, codes and constants.
// No dependencies; every other file in rtl/ but ssid_ram imports this package.
package ssid_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 3;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] value;
  } ssid_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  entry_count;
  } ssid_out_t;

  // Compare unit result
  typedef struct packed {
    logic precedes;
    logic equal;
  } cmp_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SHIFT,
    S_FLUSH,
    S_PUT,
    S_RESP
  } seq_state_t;

endpackage

### rtl/ssid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/ssid_cmp.sv
// Shared compare unit: orders a stored entry against the probe value.
// Depends on ssid_pkg.
module ssid_cmp (
  input  logic [ssid_pkg::DATA_W-1:0]        entry,
  input  logic signed [ssid_pkg::DATA_W-1:0] probe,
  input  logic                               descending,
  output ssid_pkg::cmp_res_t                 res
);
  import ssid_pkg::*;

  logic signed [DATA_W-1:0] entry_s;

  assign entry_s = $signed(entry);

  // entry stands strictly before probe in the configured order
  always_comb begin
    res.precedes = descending ? (entry_s > probe) : (entry_s < probe);
    res.equal    = (entry_s == probe);
  end

endmodule

### rtl/ssid_seq.sv
// Sequencer and item registers: linear search, then one-entry-per-cycle
// shift through the entry RAM. Depends on ssid_pkg.
module ssid_seq #(
  parameter int CAPACITY = ssid_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  ssid_pkg::ssid_in_t                 in_data,
  output logic                               busy,
  output logic                               out_valid,
  output ssid_pkg::ssid_out_t                out_data,
  input  ssid_pkg::cmp_res_t                 cmp_res,
  output logic signed [ssid_pkg::DATA_W-1:0] probe,
  output logic [AW-1:0]                      rd_addr,
  input  logic [ssid_pkg::DATA_W-1:0]        rd_data,
  output logic                               wr_en,
  output logic [AW-1:0]                      wr_addr,
  output logic [ssid_pkg::DATA_W-1:0]        wr_data
);
  import ssid_pkg::*;

  seq_state_t               state_r, state_nxt;
  logic                     cmd_r, cmd_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic                     hit_r, hit_nxt;
  logic [AW-1:0]            j_r, j_nxt;
  logic                     wv_r, wv_nxt;
  logic [AW-1:0]            wa_r, wa_nxt;
  logic [STATUS_W-1:0]      status_r, status_nxt;
  logic [CW-1:0]            count_r, count_nxt;

  logic [CW-1:0] pos_p1;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_after;
  logic          is_ins;
  logic          full;
  logic [31:0]   pos_ext;
  logic [31:0]   cnt_ext;

  assign pos_p1 = pos_r + CW'(1);
  assign cnt_m1 = count_r - CW'(1);
  assign is_ins = (cmd_r == CMD_INSERT);
  assign full   = (count_r == CW'(CAPACITY));
  assign probe  = value_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (count_r == '0) ? S_DECIDE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!cmp_res.precedes || (pos_p1 == count_r)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (is_ins) begin
          if (hit_r || full)        state_nxt = S_RESP;
          else if (pos_r == count_r) state_nxt = S_PUT;
          else                       state_nxt = S_SHIFT;
        end else begin
          if (!hit_r)                state_nxt = S_RESP;
          else if (pos_p1 == count_r) state_nxt = S_RESP;
          else                        state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (is_ins ? (j_r == pos_r[AW-1:0]) : (j_r == cnt_m1[AW-1:0])) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: state_nxt = is_ins ? S_PUT : S_RESP;
      S_PUT:   state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // item and datapath registers
  always_comb begin
    cmd_nxt    = cmd_r;
    value_nxt  = value_r;
    pos_nxt    = pos_r;
    hit_nxt    = hit_r;
    j_nxt      = j_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    wv_nxt     = (state_r == S_SHIFT);
    wa_nxt     = is_ins ? (j_r + AW'(1)) : (j_r - AW'(1));
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_data.cmd;
          value_nxt = in_data.value;
          pos_nxt   = '0;
          hit_nxt   = 1'b0;
        end
      end
      S_SEARCH: begin
        if (cmp_res.precedes) pos_nxt = pos_p1;
        else                  hit_nxt = cmp_res.equal;
      end
      S_DECIDE: begin
        if (is_ins) begin
          j_nxt = cnt_m1[AW-1:0];
          if (hit_r) begin
            status_nxt = ST_DUPLICATE;
          end else if (full) begin
            status_nxt = ST_FULL;
            pos_nxt    = '0;
          end else begin
            status_nxt = ST_INSERTED;
          end
        end else begin
          j_nxt = pos_p1[AW-1:0];
          if (hit_r) begin
            status_nxt = ST_DELETED;
          end else begin
            status_nxt = ST_NOT_FOUND;
            pos_nxt    = '0;
          end
        end
      end
      S_SHIFT: begin
        j_nxt = is_ins ? (j_r - AW'(1)) : (j_r + AW'(1));
      end
      S_RESP: begin
        count_nxt = cnt_after;
      end
      default: ;
    endcase
  end

  // count after this item
  always_comb begin
    case (status_r)
      ST_INSERTED: cnt_after = count_r + CW'(1);
      ST_DELETED:  cnt_after = cnt_m1;
      default:     cnt_after = count_r;
    endcase
  end

  // outputs: RAM ports, handshake, result
  always_comb begin
    rd_addr = '0;
    case (state_r)
      S_SEARCH: rd_addr = pos_p1[AW-1:0];
      S_SHIFT:  rd_addr = j_r;
      default:  rd_addr = '0;
    endcase

    if (state_r == S_PUT) begin
      wr_en   = 1'b1;
      wr_addr = pos_r[AW-1:0];
      wr_data = value_r;
    end else begin
      wr_en   = wv_r;
      wr_addr = wa_r;
      wr_data = rd_data;
    end

    pos_ext              = 32'(pos_r);
    cnt_ext              = 32'(cnt_after);
    busy                 = (state_r != S_IDLE);
    out_valid            = (state_r == S_RESP);
    out_data.status      = status_r;
    out_data.position    = pos_ext[POS_W-1:0];
    out_data.entry_count = cnt_ext[COUNT_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      wv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wv_r    <= wv_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    value_r  <= value_nxt;
    pos_r    <= pos_nxt;
    hit_r    <= hit_nxt;
    j_r      <= j_nxt;
    wa_r     <= wa_nxt;
    status_r <= status_nxt;
  end

endmodule

### rtl/sorted_set_insert_delete.sv
// Sorted set of distinct signed values with insert and delete items.
// Depends on ssid_pkg, ssid_ram, ssid_cmp, ssid_seq.
//
//   channel | ports                        | handshake
//   --------+------------------------------+-----------------------------------
//   input   | start, busy, in_data         | taken when start && !busy
//   result  | out_valid, out_data          | one-cycle strobe, no back-pressure
//   config  | cfg_wr_en, cfg_wr_data       | written when cfg_wr_en is high
//
// An item searches the entries in order, then, when entries must move, shifts
// them and, for a new insert, stores its value; the next item is taken only
// after its result. The entry RAM is single-read, single-write and there is
// one compare unit, so search and shift each handle one entry per cycle.
// Reset is synchronous, active low, and empties the set; no clearing pass.
// busy stays high from acceptance through the result strobe.
module sorted_set_insert_delete #(
  parameter int CAPACITY = ssid_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ssid_pkg::ssid_in_t  in_data,
  output logic                busy,
  output logic                out_valid,
  output ssid_pkg::ssid_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);
  import ssid_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic                     desc_r;
  cmp_res_t                 cmp_res;
  logic signed [DATA_W-1:0] probe;
  logic [AW-1:0]            rd_addr;
  logic [DATA_W-1:0]        rd_data;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [DATA_W-1:0]        wr_data;

  // order register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r <= 1'b0;
    end else if (cfg_wr_en) begin
      desc_r <= cfg_wr_data;
    end
  end

  ssid_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmp_res   (cmp_res),
    .probe     (probe),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  ssid_cmp u_cmp (
    .entry      (rd_data),
    .probe      (probe),
    .descending (desc_r),
    .res        (cmp_res)
  );

  ssid_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

### rtl/ssid_chk.sv
// Port-level checker for sorted_set_insert_delete, bound to the top level.
// Depends on ssid_pkg.
module ssid_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input ssid_pkg::ssid_out_t out_data
);
  import ssid_pkg::*;

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accepted");

  // a result only shows while an item is in work
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // each result strobe lasts one cycle and frees the block
  a_result_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("block not idle after result");

  // status codes stay in range
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_INSERTED || out_data.status == ST_DUPLICATE ||
                   out_data.status == ST_DELETED || out_data.status == ST_NOT_FOUND ||
                   out_data.status == ST_FULL))
    else $error("unknown status code");

endmodule

bind sorted_set_insert_delete ssid_chk u_ssid_chk (.*);

### tb/tb_top.sv
// Self-checking bench for sorted_set_insert_delete: directed and random insert/delete items.
// Depends on ssid_pkg and the RTL top; a tracker class predicts each result and checks it.
module tb_top;
  import ssid_pkg::*;

  localparam int SET_CAP = CAPACITY_DEF;

  // Mirror of the sorted store: predicts results and matches them in order
  class set_tracker;
    logic signed [DATA_W-1:0] entries [SET_CAP];
    int        count;
    bit        descending;
    int        errors;
    ssid_out_t due_outcomes [$];

    function new();
      count      = 0;
      descending = 1'b0;
      errors     = 0;
    endfunction

    // True when entry a sits ahead of value b under the current order
    function bit precedes(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
      return descending ? (a > b) : (a < b);
    endfunction

    // Accepted item: update the store and queue the result it must give
    function void take_item(ssid_in_t it);
      ssid_out_t res;
      int        p;
      bit        hit;
      p = 0;
      while (p < count && precedes(entries[p], it.value)) p++;
      hit = (p < count) && (entries[p] == it.value);
      res.position = POS_W'(p);
      if (it.cmd == CMD_INSERT) begin
        if (hit) begin
          res.status = ST_DUPLICATE;
        end else if (count >= SET_CAP) begin
          res.status   = ST_FULL;
          res.position = '0;
        end else begin
          for (int i = count; i > p; i--) entries[i] = entries[i-1];
          entries[p] = it.value;
          count++;
          res.status = ST_INSERTED;
        end
      end else if (hit) begin
        for (int i = p; i + 1 < count; i++) entries[i] = entries[i+1];
        count--;
        res.status = ST_DELETED;
      end else begin
        res.status   = ST_NOT_FOUND;
        res.position = '0;
      end
      res.entry_count = COUNT_W'(count);
      due_outcomes.push_back(res);
    endfunction

    // One line per mismatch
    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_outcome(ssid_out_t got);
      ssid_out_t want;
      if (due_outcomes.size() == 0) begin
        report($sformatf("unexpected result status=%0d pos=%0d count=%0d",
                         got.status, got.position, got.entry_count));
        return;
      end
      want = due_outcomes.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.position !== want.position)
        report($sformatf("position got %0d want %0d", got.position, want.position));
      if (got.entry_count !== want.entry_count)
        report($sformatf("entry_count got %0d want %0d", got.entry_count, want.entry_count));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  ssid_in_t  in_data;
  logic      busy;
  logic      out_valid;
  ssid_out_t out_data;
  logic      cfg_wr_en;
  logic      cfg_wr_data;

  set_tracker tr = new();
  int         sent;

  sorted_set_insert_delete dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_data     (in_data),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Monitors: items taken, results, order register writes
  always @(posedge clk) begin
    if (rst_n && start && !busy) tr.take_item(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tr.check_outcome(out_data);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_wr_en) tr.descending = cfg_wr_data;
  end

  function automatic ssid_in_t mk(logic op, logic [DATA_W-1:0] val);
    ssid_in_t it;
    it.cmd   = op;
    it.value = val;
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] boundary_value();
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Values lean on what is stored so hits, duplicates and neighbors are common
  function automatic logic [DATA_W-1:0] pick_value(logic op);
    int unsigned       roll;
    logic [DATA_W-1:0] base;
    roll = $urandom_range(99);
    base = (tr.count > 0) ? tr.entries[$urandom_range(tr.count - 1)] : $urandom;
    if (op == CMD_DELETE) begin
      if (roll < 65) return base;
      if (roll < 80) return $urandom_range(1) ? base + 32'd1 : base - 32'd1;
      if (roll < 88) return boundary_value();
      return $urandom;
    end
    if (roll < 45) return $urandom;
    if (roll < 60) return base;
    if (roll < 75) return base ^ (32'd1 << $urandom_range(31));
    if (roll < 85) return boundary_value();
    return 32'($urandom_range(15)) - 32'd8;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(ssid_in_t it, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold the sender off until every queued result has come back
  task automatic drain();
    while (tr.due_outcomes.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic set_order(logic desc);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= desc;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int          phase_no;
    int          len;
    int          mode;
    int          idle_pct;
    int          ins_pct;
    logic        op;
    int unsigned idle_set [3];

    idle_set    = '{0, 51, 9};
    start       = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    rst_n       = 1'b0;
    sent        = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, extremes, duplicate, first/last delete, misses
    set_order(1'b0);
    send_item(mk(CMD_DELETE, 32'd5), 0);
    send_item(mk(CMD_INSERT, 32'h0000_0000), 0);
    send_item(mk(CMD_INSERT, 32'h7fff_ffff), 0);
    send_item(mk(CMD_INSERT, 32'h8000_0000), 0);
    send_item(mk(CMD_INSERT, 32'hffff_ffff), 0);
    send_item(mk(CMD_INSERT, 32'h0000_0001), 0);
    send_item(mk(CMD_INSERT, 32'h0000_0000), 0);
    send_item(mk(CMD_DELETE, 32'h7fff_ffff), 0);
    send_item(mk(CMD_DELETE, 32'h8000_0000), 0);
    send_item(mk(CMD_DELETE, 32'd12345), 0);
    send_item(mk(CMD_INSERT, 32'h7fff_ffff), 0);
    start <= 1'b0;

    // Flip the order with entries still stored
    set_order(1'b1);
    send_item(mk(CMD_INSERT, 32'd7), 0);
    send_item(mk(CMD_DELETE, 32'h0000_0000), 0);
    send_item(mk(CMD_INSERT, 32'h8000_0000), 0);
    send_item(mk(CMD_DELETE, 32'hffff_ffff), 0);
    send_item(mk(CMD_DELETE, 32'h7fff_ffff), 0);
    start <= 1'b0;

    // Random phases: fill, drain or mixed, new order and idle rate per phase
    phase_no = 0;
    while (sent < 1050) begin
      set_order(phase_no < 2 ? phase_no[0] : logic'($urandom_range(1)));
      mode     = (phase_no < 3) ? phase_no : $urandom_range(2);
      idle_pct = idle_set[phase_no % 3];
      len      = $urandom_range(40, 160);
      case (mode)
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      for (int n = 0; n < len && sent < 1050; n++) begin
        op = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
        send_item(mk(op, pick_value(op)), idle_pct);
        sent++;
      end
      start <= 1'b0;
      phase_no++;
    end

    drain();
    repeat (2 * SET_CAP + 10) @(negedge clk);
    if (tr.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### sim.f
rtl/ssid_pkg.sv
rtl/ssid_ram.sv
rtl/ssid_cmp.sv
rtl/ssid_seq.sv
rtl/sorted_set_insert_delete.sv
rtl/ssid_chk.sv
tb/tb_top.sv
